>>> hw/rtl/tps_pkg.sv
package tps_pkg;

   localparam int FRAC_BITS       = 8;
   localparam int ANGLE_BITS      = 16;
   localparam int SINE_TABLE_BITS = 10;
   localparam int MAX_CANVAS      = 4096;
   localparam int TRIG_FRAC       = 14;

   localparam int CANVAS_BITS = 13;
   localparam int DIST_BITS   = 24;
   localparam int POS_BITS    = 20;
   localparam int TURN_BITS   = 17;
   localparam int TRIG_BITS   = 16;
   localparam int SINE_W      = 15;
   localparam int SINE_DEPTH  = 1 << SINE_TABLE_BITS;
   localparam int SINE_ABITS  = SINE_TABLE_BITS + 1;
   localparam int PROD_BITS   = DIST_BITS + TRIG_BITS;
   localparam int SUM_BITS    = 26;
   localparam int QUO_BITS    = SUM_BITS - FRAC_BITS;
   localparam int OFS_BITS    = POS_BITS + 1;

   localparam logic [ANGLE_BITS-1:0] HEADING_RESET = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
   localparam logic [ANGLE_BITS-1:0] HALF_TURN     = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

   typedef enum logic [1:0] {
      OP_FORWARD     = 2'd0,
      OP_BACKWARD    = 2'd1,
      OP_ROTATE      = 2'd2,
      OP_SET_HEADING = 2'd3
   } op_type;

   typedef struct packed {
      logic                        is_move;
      logic signed [DIST_BITS-1:0] distance;
      logic [ANGLE_BITS-1:0]       move_angle;
      logic [ANGLE_BITS-1:0]       heading;
      logic signed [TURN_BITS-1:0] turn;
      logic                        turn_valid;
   } item_type;

   typedef logic [SINE_W-1:0] sine_rom_type [0:SINE_DEPTH];

   localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

   // quarter-wave sine in q1.14, integer taylor series at about 2^-30
   function automatic sine_rom_type build_sine();
      sine_rom_type    rom;
      logic [63:0]     x;
      logic [63:0]     x2;
      logic [63:0]     term;
      logic [63:0]     prod;
      logic signed [63:0] sum;
      for (int i = 0; i <= SINE_DEPTH; i++) begin
         x    = (PIHALF_Q30 * 64'(i)) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int k = 1; k <= 8; k++) begin
            prod = (term * x2) >> 30;
            case (k)
               1: term = prod / 64'd6;
               2: term = prod / 64'd20;
               3: term = prod / 64'd42;
               4: term = prod / 64'd72;
               5: term = prod / 64'd110;
               6: term = prod / 64'd156;
               7: term = prod / 64'd210;
               default: term = prod / 64'd272;
            endcase
            if (k % 2 == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rom[i] = SINE_W'((64'(sum) + 64'd32768) >> 16);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

endpackage

>>> hw/rtl/tps_front.sv
module tps_front
   import tps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  q_full,
   output logic                  push,
   output item_type              push_item
);

   logic [ANGLE_BITS-1:0]       heading_ff;
   logic [ANGLE_BITS-1:0]       heading_in;
   op_type                      op;
   logic signed [DIST_BITS-1:0] req_dist;
   logic [ANGLE_BITS-1:0]       ang;
   logic signed [TURN_BITS-1:0] diff;
   logic signed [TURN_BITS-1:0] diff_red;

   assign op       = op_type'(req_tuser);
   assign req_dist = $signed(req_tdata[DIST_BITS-1:0]);
   assign ang      = req_tdata[DIST_BITS +: ANGLE_BITS];

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   assign diff = $signed({1'b0, ang}) - $signed({1'b0, heading_ff});

   // only a turn above half is folded back
   always_comb begin
      if (diff > $signed({1'b0, HALF_TURN})) begin
         diff_red = diff - $signed({1'b1, {ANGLE_BITS{1'b0}}});
      end else begin
         diff_red = diff;
      end
   end

   always_comb begin
      heading_in           = heading_ff;
      push_item.is_move    = 1'b0;
      push_item.distance   = req_dist;
      push_item.move_angle = heading_ff;
      push_item.turn       = '0;
      push_item.turn_valid = 1'b0;
      case (op)
         OP_FORWARD: begin
            push_item.is_move = 1'b1;
         end
         OP_BACKWARD: begin
            push_item.is_move    = 1'b1;
            push_item.move_angle = heading_ff + HALF_TURN;
         end
         OP_ROTATE: begin
            heading_in           = heading_ff - ang;
            push_item.turn       = $signed({1'b0, ang});
            push_item.turn_valid = 1'b1;
         end
         OP_SET_HEADING: begin
            if (ang != heading_ff) begin
               heading_in           = ang;
               push_item.turn       = -diff_red;
               push_item.turn_valid = 1'b1;
            end
         end
         default: begin
            heading_in = heading_ff;
         end
      endcase
      push_item.heading = heading_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= HEADING_RESET;
      end else if (push) begin
         heading_ff <= heading_in;
      end
   end

endmodule

>>> hw/rtl/tps_queue.sv
module tps_queue
   import tps_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type              mem_ff [0:DEPTH-1];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [CNT_BITS-1:0]   count_ff;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> hw/rtl/tps_back.sv
module tps_back
   import tps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CANVAS_BITS-1:0] canvas_width,
   input  logic [CANVAS_BITS-1:0] canvas_height,
   input  logic                   q_empty,
   input  item_type               q_item,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [79:0]            rsp_tdata,
   output logic [0:0]             rsp_tuser
);

   typedef enum logic [2:0] {
      S_IDLE, S_ROM, S_MULX, S_MULY, S_SUMY, S_DIV, S_FIX, S_DONE
   } state_type;

   state_type                   state_ff;
   item_type                    item_ff;
   logic [SINE_W-1:0]           lo_ff;
   logic [SINE_W-1:0]           hi_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [SUM_BITS-1:0]  sum_x_ff;
   logic signed [SUM_BITS-1:0]  sum_y_ff;
   logic [QUO_BITS-1:0]         num_x_ff;
   logic [QUO_BITS-1:0]         num_y_ff;
   logic [CANVAS_BITS-1:0]      rem_x_ff;
   logic [CANVAS_BITS-1:0]      rem_y_ff;
   logic [4:0]                  count_ff;
   logic signed [POS_BITS-1:0]  pen_x_ff;
   logic signed [POS_BITS-1:0]  pen_y_ff;
   logic                        out_valid_ff;
   logic [79:0]                 out_data_ff;
   logic [0:0]                  out_user_ff;

   logic [CANVAS_BITS-1:0]      wx;
   logic [CANVAS_BITS-1:0]      wy;
   logic [OFS_BITS-1:0]         cx;
   logic [OFS_BITS-1:0]         cy;
   logic [SINE_TABLE_BITS-1:0]  idx;
   logic [SINE_ABITS-1:0]       lo_addr;
   logic [SINE_ABITS-1:0]       hi_addr;
   logic signed [TRIG_BITS-1:0] lo_s;
   logic signed [TRIG_BITS-1:0] hi_s;
   logic signed [TRIG_BITS-1:0] cos_v;
   logic signed [TRIG_BITS-1:0] sin_v;
   logic signed [TRIG_BITS-1:0] mul_op;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] round_in;
   logic signed [SUM_BITS-1:0]  delta;
   logic signed [POS_BITS-1:0]  pen_sel;
   logic [OFS_BITS-1:0]         ofs_sel;
   logic signed [SUM_BITS-1:0]  sum_in;
   logic signed [QUO_BITS-1:0]  quo_x;
   logic signed [QUO_BITS-1:0]  quo_y;
   logic [CANVAS_BITS:0]        trial_x;
   logic [CANVAS_BITS:0]        trial_y;
   logic [CANVAS_BITS-1:0]      rem_x_in;
   logic [CANVAS_BITS-1:0]      rem_y_in;
   logic [CANVAS_BITS-1:0]      fold_x;
   logic [CANVAS_BITS-1:0]      fold_y;
   logic [OFS_BITS-1:0]         pos_x_raw;
   logic [OFS_BITS-1:0]         pos_y_raw;
   logic signed [OFS_BITS:0]    x_lo;
   logic signed [OFS_BITS:0]    x_hi;
   logic                        out_load;

   function automatic logic [CANVAS_BITS-1:0] clamp_canvas(input logic [CANVAS_BITS-1:0] r);
      if (r == '0) begin
         return CANVAS_BITS'(1);
      end else if (r > CANVAS_BITS'(MAX_CANVAS)) begin
         return CANVAS_BITS'(MAX_CANVAS);
      end else begin
         return r;
      end
   endfunction

   assign wx = clamp_canvas(canvas_width);
   assign wy = clamp_canvas(canvas_height);
   assign cx = {wx[CANVAS_BITS-1:1], {FRAC_BITS{1'b0}}};
   assign cy = {wy[CANVAS_BITS-1:1], {FRAC_BITS{1'b0}}};

   // quadrant symmetry around the quarter-wave table
   assign idx     = item_ff.move_angle[ANGLE_BITS-3 -: SINE_TABLE_BITS];
   assign lo_addr = {1'b0, idx};
   assign hi_addr = SINE_ABITS'(SINE_DEPTH) - lo_addr;
   assign lo_s    = $signed({1'b0, lo_ff});
   assign hi_s    = $signed({1'b0, hi_ff});

   always_comb begin
      case (item_ff.move_angle[ANGLE_BITS-1 -: 2])
         2'd0: begin
            sin_v = lo_s;
            cos_v = hi_s;
         end
         2'd1: begin
            sin_v = hi_s;
            cos_v = -lo_s;
         end
         2'd2: begin
            sin_v = -lo_s;
            cos_v = -hi_s;
         end
         default: begin
            sin_v = -hi_s;
            cos_v = lo_s;
         end
      endcase
   end

   assign mul_op   = (state_ff == S_MULX) ? cos_v : sin_v;
   assign prod_in  = item_ff.distance * mul_op;
   // round to nearest, ties up
   assign round_in = prod_ff + PROD_BITS'(1 << (TRIG_FRAC - 1));
   assign delta    = round_in[PROD_BITS-1:TRIG_FRAC];
   assign pen_sel  = (state_ff == S_MULY) ? pen_x_ff : pen_y_ff;
   assign ofs_sel  = (state_ff == S_MULY) ? cx : cy;
   assign sum_in   = SUM_BITS'(pen_sel) + delta + $signed(SUM_BITS'(ofs_sel));

   assign quo_x = sum_x_ff[SUM_BITS-1:FRAC_BITS];
   assign quo_y = sum_in[SUM_BITS-1:FRAC_BITS];

   // one remainder bit per cycle on each axis
   assign trial_x  = {rem_x_ff, num_x_ff[QUO_BITS-1]};
   assign trial_y  = {rem_y_ff, num_y_ff[QUO_BITS-1]};
   assign rem_x_in = (trial_x >= {1'b0, wx}) ? CANVAS_BITS'(trial_x - {1'b0, wx})
                                            : trial_x[CANVAS_BITS-1:0];
   assign rem_y_in = (trial_y >= {1'b0, wy}) ? CANVAS_BITS'(trial_y - {1'b0, wy})
                                            : trial_y[CANVAS_BITS-1:0];

   // euclidean fixup for negative sums, exact multiples stay at zero
   assign fold_x = (sum_x_ff[SUM_BITS-1] && rem_x_ff != '0) ? wx - rem_x_ff : rem_x_ff;
   assign fold_y = (sum_y_ff[SUM_BITS-1] && rem_y_ff != '0) ? wy - rem_y_ff : rem_y_ff;
   assign pos_x_raw = {1'b0, fold_x[CANVAS_BITS-2:0], sum_x_ff[FRAC_BITS-1:0]} - cx;
   assign pos_y_raw = {1'b0, fold_y[CANVAS_BITS-2:0], sum_y_ff[FRAC_BITS-1:0]} - cy;

   assign pop      = (state_ff == S_IDLE) && !q_empty;
   assign out_load = (state_ff == S_DONE) && (!out_valid_ff || rsp_tready);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  item_ff  <= q_item;
                  state_ff <= q_item.is_move ? S_ROM : S_DONE;
               end
            end
            S_ROM: begin
               lo_ff    <= SINE_ROM[lo_addr];
               hi_ff    <= SINE_ROM[hi_addr];
               state_ff <= S_MULX;
            end
            S_MULX: begin
               prod_ff  <= prod_in;
               state_ff <= S_MULY;
            end
            S_MULY: begin
               sum_x_ff <= sum_in;
               prod_ff  <= prod_in;
               state_ff <= S_SUMY;
            end
            S_SUMY: begin
               sum_y_ff <= sum_in;
               num_x_ff <= quo_x[QUO_BITS-1] ? QUO_BITS'(-quo_x) : QUO_BITS'(quo_x);
               num_y_ff <= quo_y[QUO_BITS-1] ? QUO_BITS'(-quo_y) : QUO_BITS'(quo_y);
               rem_x_ff <= '0;
               rem_y_ff <= '0;
               count_ff <= 5'(QUO_BITS - 1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_x_ff <= rem_x_in;
               rem_y_ff <= rem_y_in;
               num_x_ff <= num_x_ff << 1;
               num_y_ff <= num_y_ff << 1;
               count_ff <= count_ff - 1'b1;
               if (count_ff == '0) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               pen_x_ff <= $signed(pos_x_raw[POS_BITS-1:0]);
               pen_y_ff <= $signed(pos_y_raw[POS_BITS-1:0]);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_load) begin
                  out_data_ff  <= {7'b0, item_ff.turn, item_ff.heading, pen_y_ff, pen_x_ff};
                  out_user_ff  <= item_ff.turn_valid;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign x_lo = -$signed({1'b0, cx});
   assign x_hi = $signed({1'b0, wx, {FRAC_BITS{1'b0}}}) - $signed({1'b0, cx});

   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_x_ff < wx && rem_y_ff < wy))
      else $error("remainder not below canvas size");

   a_x_in_canvas: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIX) |=>
         ($signed(OFS_BITS'(pen_x_ff)) >= x_lo && $signed(OFS_BITS'(pen_x_ff)) < x_hi))
      else $error("pen x outside canvas after wrap");

   a_move_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_DONE) |-> item_ff.is_move)
      else $error("non-move request in arithmetic path");

endmodule

>>> hw/rtl/turtle_pen_step_wrap.sv
// channel   dir  contents
// req_*     in   tdata: distance[23:0], angle[39:24]; tuser: operation[1:0]
// rsp_*     out  tdata: pos_x, pos_y, heading, turn, zero pad; tuser: turn_valid
// csr_*     in   index 0 canvas_width, index 1 canvas_height
//
// a move request goes through the back end as a table read, two
// multiplies on one multiplier, then a bit-serial remainder for the wrap
// rotate and set heading skip the arithmetic path; heading is tracked at accept time
// requests are queued ahead of the back end so the request side stalls only when full
// synchronous active-high reset: pen at origin, heading a quarter turn, canvas 512
module turtle_pen_step_wrap
   import tps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,   // distance, angle
   input  logic [1:0]             req_tuser,   // operation
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [79:0]            rsp_tdata,   // pos_x, pos_y, heading, turn, pad
   output logic [0:0]             rsp_tuser,   // turn_valid
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [CANVAS_BITS-1:0] csr_wdata
);

   localparam int CSR_WIDTH  = 0;
   localparam int CSR_HEIGHT = 1;

   logic [CANVAS_BITS-1:0] canvas_width_ff;
   logic [CANVAS_BITS-1:0] canvas_height_ff;
   logic                   q_full;
   logic                   q_empty;
   logic                   push;
   logic                   pop;
   item_type               push_item;
   item_type               pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= CANVAS_BITS'(512);
         canvas_height_ff <= CANVAS_BITS'(512);
      end else if (csr_we) begin
         if (csr_index == 1'(CSR_WIDTH)) begin
            canvas_width_ff <= csr_wdata;
         end else if (csr_index == 1'(CSR_HEIGHT)) begin
            canvas_height_ff <= csr_wdata;
         end
      end
   end

   tps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   tps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   tps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .canvas_width  (canvas_width_ff),
      .canvas_height (canvas_height_ff),
      .q_empty       (q_empty),
      .q_item        (pop_item),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

>>> verif/turtle_pen_step_checker.sv
module turtle_pen_step_checker
   import tps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [39:0]            req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [79:0]            rsp_tdata,
   input  logic [0:0]             rsp_tuser,
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [CANVAS_BITS-1:0] csr_wdata,
   output int                     fail_count,
   output int                     pending_count,
   output int                     moves_seen,
   output int                     turns_seen
);

   typedef struct packed {
      logic signed [POS_BITS-1:0]  pos_x;
      logic signed [POS_BITS-1:0]  pos_y;
      logic [ANGLE_BITS-1:0]       heading;
      logic signed [TURN_BITS-1:0] turn;
      logic                        turn_valid;
   } pen_result_type;

   pen_result_type pen_results_q[$];
   longint      track_x, track_y;
   logic [ANGLE_BITS-1:0] track_heading;
   logic [CANVAS_BITS-1:0] width_reg, height_reg;
   longint      quarter_sine [0:1024];

   // quarter-wave table from the same integer series, computed independently
   initial begin
      longint unsigned x, x2, term;
      longint s;
      for (int i = 0; i <= 1024; i++) begin
         x = (64'd1686629713 * i) / 1024;
         x2 = (x * x) >> 30;
         term = x;
         s = x;
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2) s -= term;
            else s += term;
         end
         if (s < 0) s = 0;
         quarter_sine[i] = (s + 32768) >>> 16;
      end
   end

   function automatic longint scaled_product(longint v);
      return (v + 8192) >>> 14;
   endfunction

   function automatic longint wrap_coord(longint p, longint d, logic [CANVAS_BITS-1:0] r);
      longint w, m, c, q;
      w = (r == 0) ? 1 : (r > MAX_CANVAS) ? MAX_CANVAS : r;
      m = w * 256;
      c = (w / 2) * 256;
      q = (p + d + c) % m;
      if (q < 0) q += m;
      return q - c;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   task automatic predict_pen(logic [1:0] opc, logic signed [DIST_BITS-1:0] move_len,
                              logic [ANGLE_BITS-1:0] ang);
      pen_result_type r;
      logic [ANGLE_BITS-1:0] a;
      longint cs, sn, lo, hi, diff;
      int idx;
      r.turn = '0;
      r.turn_valid = 1'b0;
      if (opc == OP_FORWARD || opc == OP_BACKWARD) begin
         a = track_heading;
         if (opc == OP_BACKWARD) a = a + HALF_TURN;
         idx = a[13:4];
         lo = quarter_sine[idx];
         hi = quarter_sine[1024 - idx];
         case (a[15:14])
            2'd0: begin sn = lo; cs = hi; end
            2'd1: begin sn = hi; cs = -lo; end
            2'd2: begin sn = -lo; cs = -hi; end
            default: begin sn = -hi; cs = lo; end
         endcase
         track_x = wrap_coord(track_x, scaled_product(longint'(move_len) * cs), width_reg);
         track_y = wrap_coord(track_y, scaled_product(longint'(move_len) * sn), height_reg);
         moves_seen++;
      end else if (opc == OP_ROTATE) begin
         track_heading = track_heading - ang;
         r.turn = TURN_BITS'(ang);
         r.turn_valid = 1'b1;
         turns_seen++;
      end else if (ang != track_heading) begin
         diff = longint'(ang) - longint'(track_heading);
         if (diff > 32768) diff -= 65536;
         track_heading = ang;
         r.turn = TURN_BITS'(-diff);
         r.turn_valid = 1'b1;
         turns_seen++;
      end
      r.pos_x = POS_BITS'(track_x);
      r.pos_y = POS_BITS'(track_y);
      r.heading = track_heading;
      pen_results_q.push_back(r);
   endtask

   always @(posedge clock) begin
      pen_result_type want;
      if (reset) begin
         track_x = 0;
         track_y = 0;
         track_heading = HEADING_RESET;
         width_reg = 512;
         height_reg = 512;
         pen_results_q.delete();
         fail_count = 0;
         moves_seen = 0;
         turns_seen = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == 1'b0) width_reg = csr_wdata;
            else height_reg = csr_wdata;
         end
         if (req_tvalid && req_tready)
            predict_pen(req_tuser, req_tdata[23:0], req_tdata[39:24]);
         if (rsp_tvalid && rsp_tready) begin
            if (pen_results_q.size() == 0) begin
               $display("unexpected result at %0t", $time);
               fail_count++;
            end else begin
               want = pen_results_q.pop_front();
               if ($signed(rsp_tdata[19:0]) != want.pos_x)
                  report_mismatch("pos_x", $signed(rsp_tdata[19:0]), want.pos_x);
               if ($signed(rsp_tdata[39:20]) != want.pos_y)
                  report_mismatch("pos_y", $signed(rsp_tdata[39:20]), want.pos_y);
               if (rsp_tdata[55:40] != want.heading)
                  report_mismatch("heading", rsp_tdata[55:40], want.heading);
               if ($signed(rsp_tdata[72:56]) != want.turn)
                  report_mismatch("turn", $signed(rsp_tdata[72:56]), want.turn);
               if (rsp_tuser[0] != want.turn_valid)
                  report_mismatch("turn_valid", rsp_tuser[0], want.turn_valid);
            end
         end
      end
      pending_count = pen_results_q.size();
   end

endmodule

>>> verif/tb_turtle_pen_step_wrap.sv
module tb_turtle_pen_step_wrap;
   import tps_pkg::*;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [39:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [79:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_we;
   logic [0:0] csr_index;
   logic [CANVAS_BITS-1:0] csr_wdata;
   int fail_count, pending_count, moves_seen, turns_seen;
   int send_idle_pct, recv_idle_pct, hold_cycles, quiet_cycles, requests_sent;

   turtle_pen_step_wrap dut (.*);

   turtle_pen_step_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= 5000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_request(logic [1:0] opc, logic [23:0] step_len, logic [15:0] ang);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= opc;
      req_tdata <= {ang, step_len};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_canvas(logic idx, logic [CANVAS_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(int n);
      logic [1:0] opc;
      logic [23:0] step_len;
      for (int i = 0; i < n; i++) begin
         opc = 2'($urandom_range(3));
         case ($urandom_range(3))
            0: step_len = 24'($urandom);
            1: step_len = 24'($signed($urandom_range(4000)) - 2000);
            2: step_len = 24'($signed($urandom_range(400000)) - 200000);
            default: step_len = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         endcase
         send_request(opc, step_len, ($urandom_range(3) == 0) ? 16'($urandom_range(7) * 8192)
                                                              : 16'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_FORWARD;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_cycles = 0;
      requests_sent = 0;
      send_idle_pct = 6;
      recv_idle_pct = 63;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, each operation, set heading to itself
      send_request(OP_FORWARD, 24'h7FFFFF, 16'h0000);
      send_request(OP_BACKWARD, 24'h800000, 16'hFFFF);
      send_request(OP_FORWARD, 24'd0, 16'h0000);
      send_request(OP_ROTATE, 24'd0, 16'h0000);
      send_request(OP_ROTATE, 24'd0, 16'hFFFF);
      send_request(OP_SET_HEADING, 24'd0, 16'hFFFF);
      send_request(OP_SET_HEADING, 24'd0, 16'hFFFF);
      send_request(OP_SET_HEADING, 24'd0, 16'h0000);
      send_request(OP_SET_HEADING, 24'd0, 16'hC000);
      send_request(OP_FORWARD, 24'hFFFFFF, 16'h0000);
      send_request(OP_SET_HEADING, 24'd0, 16'h4000);
      // exact negative multiple of the canvas leaves the pen where it was
      send_request(OP_BACKWARD, 24'd131072, 16'h0000);
      send_request(OP_SET_HEADING, 24'd0, 16'h2000);
      send_request(OP_FORWARD, 24'h123456, 16'h0000);
      drain_results();

      write_canvas(1'b0, 13'd0);
      write_canvas(1'b1, 13'd1);
      random_phase(60);
      drain_results();
      write_canvas(1'b0, 13'h1FFF);
      write_canvas(1'b1, 13'd4096);
      random_phase(150);
      // receiver holds off while the sender keeps offering
      hold_cycles = 400;
      random_phase(20);
      drain_results();
      send_idle_pct = 63;
      recv_idle_pct = 6;
      write_canvas(1'b0, 13'd3);
      write_canvas(1'b1, 13'd640);
      random_phase(300);
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_canvas(1'b0, 13'd512);
      write_canvas(1'b1, 13'd17);
      random_phase(300);
      drain_results();

      $display("sent %0d requests: %0d moves, %0d rotations reported", requests_sent,
               moves_seen, turns_seen);
      $display("canvas sizes covered 0, 1, 3, 17, 512, 640, 4096 and above the maximum");
      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
